// ===== design/vtgd_pkg.sv =====
// shared types, command codes and helper functions for the geometry decoder
package vtgd_pkg;

  localparam int unsigned WORD_W   = 32;
  localparam int unsigned COUNT_W  = 29;
  localparam int unsigned EXTENT_W = 16;

  localparam logic [EXTENT_W-1:0] EXTENT_RESET = 16'd4096;

  // command ids in the low bits of a command word
  localparam logic [2:0] CMD_MOVE_TO = 3'd1;
  localparam logic [2:0] CMD_LINE_TO = 3'd2;

  typedef enum logic [1:0] {
    PH_CMD = 2'd0,
    PH_DX  = 2'd1,
    PH_DY  = 2'd2
  } phase_t;

  // sticky out-of-tile flags
  typedef struct packed {
    logic west;
    logic east;
    logic south;
    logic north;
  } marks_t;

  typedef struct packed {
    logic                     point_valid;
    logic signed [WORD_W-1:0] x;
    logic signed [WORD_W-1:0] y;
    logic                     starts_line;
    logic                     inside_tile;
    marks_t                   marks;
    logic                     tile_done;
  } result_t;

  // zigzag decode, logical shift
  function automatic logic [WORD_W-1:0] zigzag(input logic [WORD_W-1:0] p);
    return (p >> 1) ^ {WORD_W{p[0]}};
  endfunction

  // signed value above an unsigned extent
  function automatic logic above_extent(input logic [WORD_W-1:0] v,
                                        input logic [EXTENT_W-1:0] ext);
    return !v[WORD_W-1] && (v[WORD_W-2:0] > {{(WORD_W-1-EXTENT_W){1'b0}}, ext});
  endfunction

endpackage

// ===== design/vtgd_if.sv =====
// handshake channels: geometry words in, decoded points out, extent writes
interface vtgd_word_if;
  import vtgd_pkg::*;
  logic              valid;
  logic              ready;
  logic [WORD_W-1:0] word;
  logic              last_word;

  modport source (output valid, output word, output last_word, input ready);
  modport sink (input valid, input word, input last_word, output ready);
endinterface

interface vtgd_point_if;
  import vtgd_pkg::*;
  logic                     valid;
  logic                     ready;
  logic                     point_valid;
  logic signed [WORD_W-1:0] x;
  logic signed [WORD_W-1:0] y;
  logic                     starts_line;
  logic                     inside_tile;
  logic                     beyond_north;
  logic                     beyond_south;
  logic                     beyond_east;
  logic                     beyond_west;
  logic                     tile_done;

  modport source (output valid, output point_valid, output x, output y,
                  output starts_line, output inside_tile, output beyond_north,
                  output beyond_south, output beyond_east, output beyond_west,
                  output tile_done, input ready);
  modport sink (input valid, input point_valid, input x, input y,
                input starts_line, input inside_tile, input beyond_north,
                input beyond_south, input beyond_east, input beyond_west,
                input tile_done, output ready);
endinterface

interface vtgd_cfg_if;
  import vtgd_pkg::*;
  logic                valid;
  logic                ready;
  logic [EXTENT_W-1:0] data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

// ===== design/vector_tile_geometry_decoder_unit.sv =====
// vector tile geometry decoder: top level
// an accepted word passes the input reg, then the result reg, before its result word
// throughput: one word per cycle unless results stall; single decode/add/compare pass
// words that give no result (commands, dx) drain without touching the result reg
// rst (synchronous) clears control state and the tile state; extent returns to 4096
// a word marked last always yields a result and clears the per-tile state
module vector_tile_geometry_decoder_unit
  import vtgd_pkg::*;
(
  input  logic         clk,
  input  logic         rst,
  vtgd_cfg_if.sink     cfg,
  vtgd_word_if.sink    geom,
  vtgd_point_if.source result
);

  // extent register; write it only while idle, the block itself does not enforce this
  logic [EXTENT_W-1:0] tile_extent;

  // input register
  logic              s1_valid;
  logic [WORD_W-1:0] s1_word;
  logic              s1_last;

  // decoder state
  phase_t             phase, phase_next;
  logic [COUNT_W-1:0] repeats_left, repeats_left_next;
  logic               is_move, is_move_next;
  logic [WORD_W-1:0]  cur_x, cur_x_next;
  logic [WORD_W-1:0]  cur_y, cur_y_next;
  logic [WORD_W-1:0]  pending_dx, pending_dx_next;
  marks_t             marks, marks_next;

  // result register
  logic    res_valid;
  result_t res, res_next;

  logic              point;
  logic              produces;
  logic              advance;
  logic [WORD_W-1:0] zz;
  logic [2:0]        cmd_id;
  logic [COUNT_W-1:0] cmd_cnt;

  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      tile_extent <= EXTENT_RESET;
    end else if (cfg.valid) begin
      tile_extent <= cfg.data;
    end
  end

  // an item leaves the input reg when it has no result or the result reg frees up
  assign produces   = point || s1_last;
  assign advance    = s1_valid && (!produces || !res_valid || result.ready);
  assign geom.ready = !s1_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (geom.ready) begin
      s1_valid <= geom.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (geom.ready && geom.valid) begin
      s1_word <= geom.word;
      s1_last <= geom.last_word;
    end
  end

  // decode pass: zigzag, one add per axis, extent compares
  assign zz      = zigzag(s1_word);
  assign cmd_id  = s1_word[2:0];
  assign cmd_cnt = s1_word[WORD_W-1:3];

  always_comb begin
    phase_next        = phase;
    repeats_left_next = repeats_left;
    is_move_next      = is_move;
    cur_x_next        = cur_x;
    cur_y_next        = cur_y;
    pending_dx_next   = pending_dx;
    marks_next        = marks;
    point             = 1'b0;
    res_next          = '0;

    unique case (phase)
      PH_DX: begin
        pending_dx_next = zz;
        phase_next      = PH_DY;
      end
      PH_DY: begin
        cur_x_next        = cur_x + pending_dx;
        cur_y_next        = cur_y + zz;
        point             = 1'b1;
        repeats_left_next = repeats_left - COUNT_W'(1);
        phase_next        = (repeats_left_next == '0) ? PH_CMD : PH_DX;
        if (cur_y_next[WORD_W-1])                  marks_next.north = 1'b1;
        if (above_extent(cur_y_next, tile_extent)) marks_next.south = 1'b1;
        if (above_extent(cur_x_next, tile_extent)) marks_next.east  = 1'b1;
        if (cur_x_next[WORD_W-1])                  marks_next.west  = 1'b1;
      end
      default: begin
        // command word; the unused phase code lands here too
        if ((cmd_id == CMD_MOVE_TO || cmd_id == CMD_LINE_TO) && cmd_cnt != '0) begin
          repeats_left_next = cmd_cnt;
          is_move_next      = (cmd_id == CMD_MOVE_TO);
          phase_next        = PH_DX;
        end else begin
          phase_next = PH_CMD;
        end
      end
    endcase

    res_next.point_valid = point;
    res_next.x           = cur_x_next;
    res_next.y           = cur_y_next;
    res_next.starts_line = point && is_move;
    res_next.inside_tile = point && !cur_x_next[WORD_W-1] && !cur_y_next[WORD_W-1]
                           && !above_extent(cur_x_next, tile_extent)
                           && !above_extent(cur_y_next, tile_extent);
    res_next.marks       = marks_next;
    res_next.tile_done   = s1_last;

    // end of tile: per-tile state back to reset
    if (s1_last) begin
      phase_next        = PH_CMD;
      repeats_left_next = '0;
      is_move_next      = 1'b0;
      cur_x_next        = '0;
      cur_y_next        = '0;
      pending_dx_next   = '0;
      marks_next        = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase        <= PH_CMD;
      repeats_left <= '0;
      is_move      <= 1'b0;
      cur_x        <= '0;
      cur_y        <= '0;
      pending_dx   <= '0;
      marks        <= '0;
    end else if (advance) begin
      phase        <= phase_next;
      repeats_left <= repeats_left_next;
      is_move      <= is_move_next;
      cur_x        <= cur_x_next;
      cur_y        <= cur_y_next;
      pending_dx   <= pending_dx_next;
      marks        <= marks_next;
    end
  end

  // result register, loads a word only when one is produced
  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (advance && produces) begin
      res_valid <= 1'b1;
    end else if (result.ready) begin
      res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && produces) begin
      res <= res_next;
    end
  end

  assign result.valid        = res_valid;
  assign result.point_valid  = res.point_valid;
  assign result.x            = res.x;
  assign result.y            = res.y;
  assign result.starts_line  = res.starts_line;
  assign result.inside_tile  = res.inside_tile;
  assign result.beyond_north = res.marks.north;
  assign result.beyond_south = res.marks.south;
  assign result.beyond_east  = res.marks.east;
  assign result.beyond_west  = res.marks.west;
  assign result.tile_done    = res.tile_done;

`ifndef SYNTHESIS
  // a pending parameter always has a repeat left to count down
  a_repeats_live: assert property (@(posedge clk) disable iff (rst)
    phase != PH_CMD |-> repeats_left != '0)
    else $error("parameter phase with no repeats left");

  // last word clears the tile state
  a_tile_clear: assert property (@(posedge clk) disable iff (rst)
    advance && s1_last |=> phase == PH_CMD && cur_x == '0 && cur_y == '0
                           && marks == '0 && repeats_left == '0)
    else $error("tile state not cleared after last word");

  // a result without a point exists only to end a tile
  a_empty_is_done: assert property (@(posedge clk) disable iff (rst)
    res_valid && !res.point_valid |-> res.tile_done)
    else $error("pointless result word without tile end");

  // inside and line-start flags only on real points
  a_inside_point: assert property (@(posedge clk) disable iff (rst)
    res_valid && (res.inside_tile || res.starts_line) |-> res.point_valid)
    else $error("point flags set on a result without a point");

  // input stalls only behind a held word
  a_stall_cause: assert property (@(posedge clk) disable iff (rst)
    !geom.ready |-> s1_valid && res_valid && !result.ready)
    else $error("input stalled without a blocked result");
`endif

endmodule

// ===== dv/vtgd_point_checker.sv =====
`timescale 1ns / 100ps
// checker for the geometry decoder: predicts decoded points and compares result words
module vtgd_point_checker
  import vtgd_pkg::*;
(
  input  logic   clk,
  input  logic   rst,
  vtgd_cfg_if    cfg,
  vtgd_word_if   geom,
  vtgd_point_if  result,
  output int     mismatches,
  output int     open_points,
  output int     points_seen
);

  logic [EXTENT_W-1:0] extent;
  phase_t              phase;
  logic [COUNT_W-1:0]  pairs_left;
  logic                is_move;
  logic [WORD_W-1:0]   cur_x;
  logic [WORD_W-1:0]   cur_y;
  logic [WORD_W-1:0]   held_dx;
  marks_t              marks;
  result_t             points_due[$];
  int                  errors = 0;
  int                  checked = 0;

  assign mismatches  = errors;
  assign points_seen = checked;

  // zigzag decode with a logical shift
  function automatic logic [WORD_W-1:0] unzig(input logic [WORD_W-1:0] p);
    return (p >> 1) ^ (32'd0 - {31'd0, p[0]});
  endfunction

  task automatic clear_tile();
    phase      = PH_CMD;
    pairs_left = '0;
    is_move    = 1'b0;
    cur_x      = '0;
    cur_y      = '0;
    held_dx    = '0;
    marks      = '0;
  endtask

  // one accepted geometry word; queues the result word it causes, if any
  task automatic decode_word(input logic [WORD_W-1:0] w, input logic last);
    result_t r;
    logic    point;
    logic    starts;
    logic    in_tile;
    longint  sx;
    longint  sy;
    longint  ext;
    point   = 1'b0;
    starts  = 1'b0;
    in_tile = 1'b0;
    case (phase)
      PH_DX: begin
        held_dx = unzig(w);
        phase   = PH_DY;
      end
      PH_DY: begin
        cur_x = cur_x + held_dx;
        cur_y = cur_y + unzig(w);
        sx  = longint'($signed(cur_x));
        sy  = longint'($signed(cur_y));
        ext = longint'(extent);
        if (sy < 0) marks.north = 1'b1;
        if (sy > ext) marks.south = 1'b1;
        if (sx > ext) marks.east = 1'b1;
        if (sx < 0) marks.west = 1'b1;
        in_tile    = (sx >= 0 && sx <= ext && sy >= 0 && sy <= ext);
        starts     = is_move;
        point      = 1'b1;
        pairs_left = pairs_left - 1'b1;
        phase      = (pairs_left == '0) ? PH_CMD : PH_DX;
      end
      default: begin
        if ((w[2:0] == CMD_MOVE_TO || w[2:0] == CMD_LINE_TO) && w[WORD_W-1:3] != '0) begin
          pairs_left = w[WORD_W-1:3];
          is_move    = (w[2:0] == CMD_MOVE_TO);
          phase      = PH_DX;
        end else begin
          phase = PH_CMD;
        end
      end
    endcase
    if (point || last) begin
      r.point_valid = point;
      r.x           = cur_x;
      r.y           = cur_y;
      r.starts_line = starts;
      r.inside_tile = in_tile;
      r.marks       = marks;
      r.tile_done   = last;
      points_due.insert(points_due.size(), r);
    end
    if (last) clear_tile();
  endtask

  task automatic check_field(input string name, input logic [WORD_W-1:0] want,
                             input logic [WORD_W-1:0] got);
    if (want !== got) begin
      errors++;
      $display("%0t: %s expected %h got %h", $time, name, want, got);
    end
  endtask

  always @(posedge clk) begin : watch
    result_t due;
    if (rst) begin
      extent = EXTENT_RESET;
      clear_tile();
      points_due.delete();
    end else begin
      if (result.valid && result.ready) begin
        if (points_due.size() == 0) begin
          errors++;
          $display("%0t: result word with none due, x %h y %h done %b", $time,
                   result.x, result.y, result.tile_done);
        end else begin
          due = points_due.pop_front();
          checked++;
          check_field("point_valid", due.point_valid, result.point_valid);
          check_field("x", due.x, result.x);
          check_field("y", due.y, result.y);
          check_field("starts_line", due.starts_line, result.starts_line);
          check_field("inside_tile", due.inside_tile, result.inside_tile);
          check_field("beyond_north", due.marks.north, result.beyond_north);
          check_field("beyond_south", due.marks.south, result.beyond_south);
          check_field("beyond_east", due.marks.east, result.beyond_east);
          check_field("beyond_west", due.marks.west, result.beyond_west);
          check_field("tile_done", due.tile_done, result.tile_done);
        end
      end
      if (cfg.valid && cfg.ready) extent = cfg.data;
      if (geom.valid && geom.ready) decode_word(geom.word, geom.last_word);
    end
    open_points <= points_due.size();
  end

endmodule

// ===== dv/tb.sv =====
`timescale 1ns / 100ps
// testbench top for the geometry decoder: stimulus, extent writes and verdict
module tb;
  import vtgd_pkg::*;

  // ids that carry no parameters
  localparam logic [2:0] CMD_UNUSED     = 3'd0;
  localparam logic [2:0] CMD_CLOSE_PATH = 3'd7;
  localparam int         WORD_TARGET    = 1350;

  logic clk = 1'b0;
  logic rst;

  always #4 clk = ~clk;

  vtgd_cfg_if   cfg_ch ();
  vtgd_word_if  geom_ch ();
  vtgd_point_if point_ch ();

  vector_tile_geometry_decoder_unit i_dut (
    .clk    (clk),
    .rst    (rst),
    .cfg    (cfg_ch),
    .geom   (geom_ch),
    .result (point_ch)
  );

  int mismatches;
  int open_points;
  int points_seen;

  vtgd_point_checker i_checker (
    .clk         (clk),
    .rst         (rst),
    .cfg         (cfg_ch),
    .geom        (geom_ch),
    .result      (point_ch),
    .mismatches  (mismatches),
    .open_points (open_points),
    .points_seen (points_seen)
  );

  // when clear, both sides run without gaps or stalls
  bit                idle_on = 1'b1;
  int                words_sent = 0;
  int                tiles_sent = 0;
  int                extent_writes = 0;
  int                cur_extent = 4096;
  logic [WORD_W-1:0] tile_words[$];

  function automatic logic [WORD_W-1:0] cmd(input logic [2:0] id, input logic [COUNT_W-1:0] n);
    return {n, id};
  endfunction

  // zigzag encode of a signed delta
  function automatic logic [WORD_W-1:0] zz(input int d);
    return (d << 1) ^ (d >>> 31);
  endfunction

  // appends one word to the tile being built
  function automatic void add_word(input logic [WORD_W-1:0] w);
    tile_words.insert(tile_words.size(), w);
  endfunction

  // one word on the geometry channel, after a random gap
  task automatic send_word(input logic [WORD_W-1:0] w, input logic last);
    int gap;
    gap = idle_on ? $urandom_range(0, 8) : 0;
    repeat (gap) begin
      geom_ch.valid <= 1'b0;
      @(posedge clk);
    end
    geom_ch.valid     <= 1'b1;
    geom_ch.word      <= w;
    geom_ch.last_word <= last;
    do @(posedge clk); while (!geom_ch.ready);
    words_sent++;
  endtask

  // sends the queued words, the final one marked last
  task automatic send_tile();
    idle_on = ($urandom_range(0, 3) != 0);
    foreach (tile_words[i]) send_word(tile_words[i], i == tile_words.size() - 1);
    tile_words.delete();
    tiles_sent++;
  endtask

  // extent is written only once the decoder has drained
  task automatic set_extent(input logic [EXTENT_W-1:0] v);
    geom_ch.valid <= 1'b0;
    @(posedge clk);
    while (open_points != 0) @(posedge clk);
    // command and dx words leave no result but may still be in the pipe
    repeat (4) @(posedge clk);
    cfg_ch.valid <= 1'b1;
    cfg_ch.data  <= v;
    do @(posedge clk); while (!cfg_ch.ready);
    cfg_ch.valid <= 1'b0;
    cur_extent = v;
    extent_writes++;
  endtask

  function automatic logic [WORD_W-1:0] rand_param();
    int pick;
    int span;
    pick = $urandom_range(0, 9);
    span = cur_extent + cur_extent / 4 + 2;
    if (pick == 0) return $urandom();
    if (pick == 1) return zz(int'($urandom()) >>> $urandom_range(0, 16));
    return zz(int'($urandom_range(0, span)) - span / 2);
  endfunction

  // a random tile: mostly well-formed commands, some noise and truncated tiles
  task automatic build_tile();
    int       kind;
    int       ncmd;
    int       sel;
    int       pairs;
    int       cut;
    logic [2:0] id;
    kind = $urandom_range(0, 9);
    if (kind == 0) begin
      // noise: raw words of any value
      repeat ($urandom_range(1, 6)) add_word($urandom());
    end else begin
      ncmd = $urandom_range(1, 4);
      for (int c = 0; c < ncmd; c++) begin
        sel = $urandom_range(0, 9);
        if (sel == 0) begin
          // command that yields no points
          if ($urandom_range(0, 2) == 0) begin
            id = ($urandom_range(0, 1) == 0) ? CMD_MOVE_TO : CMD_LINE_TO;
            add_word(cmd(id, '0));
          end else begin
            sel = $urandom_range(0, 5);
            id  = (sel == 0) ? CMD_UNUSED : 3'(sel + 2);
            add_word(cmd(id, COUNT_W'($urandom())));
          end
        end else begin
          id    = (c == 0 || sel < 4) ? CMD_MOVE_TO : CMD_LINE_TO;
          pairs = ($urandom_range(0, 7) == 0) ? $urandom_range(1, 12) : $urandom_range(1, 4);
          add_word(cmd(id, COUNT_W'(pairs)));
          repeat (pairs) begin
            add_word(rand_param());
            add_word(rand_param());
          end
        end
      end
      if (kind == 1) begin
        // tile cut short, possibly inside a command
        cut = $urandom_range(1, tile_words.size());
        while (tile_words.size() > cut) void'(tile_words.pop_back());
      end else if (kind < 5) begin
        add_word(cmd(CMD_CLOSE_PATH, COUNT_W'(1)));
      end
    end
  endtask

  initial begin
    rst               = 1'b1;
    geom_ch.valid     = 1'b0;
    geom_ch.word      = '0;
    geom_ch.last_word = 1'b0;
    cfg_ch.valid      = 1'b0;
    cfg_ch.data       = '0;
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // reset extent: origin, the far corner, one past it, then a close with no point
    tile_words = '{cmd(CMD_MOVE_TO, COUNT_W'(1)), zz(0), zz(0),
                   cmd(CMD_LINE_TO, COUNT_W'(2)), zz(4096), zz(4096), zz(1), zz(1),
                   cmd(CMD_CLOSE_PATH, COUNT_W'(1))};
    send_tile();
    // zero-count and unused commands, extreme deltas with wrap, tile ends at a dx
    tile_words = '{cmd(CMD_MOVE_TO, '0), cmd(CMD_UNUSED, '0), cmd(CMD_LINE_TO, COUNT_W'(3)),
                   32'hffff_ffff, 32'hffff_fffe, 32'h0000_0002, 32'h0000_0003,
                   32'h5555_5555};
    send_tile();
    // lone last word on a command with the largest count
    tile_words = '{cmd(CMD_MOVE_TO, '1)};
    send_tile();
    // largest count, tile ends on the first point, north-west of the tile
    tile_words = '{cmd(CMD_MOVE_TO, '1), zz(-1), zz(-1)};
    send_tile();
    // extent of zero: only the origin is inside
    set_extent(16'd0);
    tile_words = '{cmd(CMD_MOVE_TO, COUNT_W'(2)), zz(0), zz(0), zz(1), zz(0)};
    send_tile();

    // random phases, each under its own extent
    for (int p = 0; p < 6; p++) begin
      case (p)
        0: set_extent(16'hffff);
        1: set_extent(16'd1);
        3: set_extent(16'd4096);
        default: set_extent(16'($urandom_range(1, 65535)));
      endcase
      while (words_sent < 26 + (p + 1) * (WORD_TARGET - 26) / 6) begin
        build_tile();
        send_tile();
      end
    end

    geom_ch.valid <= 1'b0;
    @(posedge clk);
    while (open_points != 0) @(posedge clk);
    repeat (6) @(posedge clk);
    $display("run covered %0d words in %0d tiles, %0d result words checked, %0d extent writes",
             words_sent, tiles_sent, points_seen, extent_writes);
    if (mismatches == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

  // result side: random stall before each word
  initial begin : drain
    int stall;
    point_ch.ready = 1'b0;
    repeat (4) @(posedge clk);
    forever begin
      stall = idle_on ? $urandom_range(0, 8) : 0;
      repeat (stall) begin
        point_ch.ready <= 1'b0;
        @(posedge clk);
      end
      point_ch.ready <= 1'b1;
      do @(posedge clk); while (!point_ch.valid);
    end
  end

  // watchdog
  initial begin
    #5_000_000;
    $display("FAILURE");
    $finish;
  end

endmodule
